@@ src/mnov_pkg.sv @@
package mnov_pkg;

  // field widths
  localparam int COORD_W    = 24;
  localparam int NORMAL_W   = 16;
  localparam int ID_W       = 20;
  localparam int ACT_W      = 3;
  localparam int CNT_W      = 21;
  localparam int SUM_W      = 44;

  // shared multiplier and accumulator widths
  localparam int MUL_W      = 25;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIFF_W     = 46;
  localparam int SPLIT      = 23;
  localparam int ACC_W      = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(1048576);

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_POINT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_VOTE        = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FLIP_NORMAL = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FLIP_FACE   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Z    = 3'd3;

  // multiplier operand selection
  localparam logic [1:0] MUL_CP = 2'd0;
  localparam logic [1:0] MUL_LO = 2'd1;
  localparam logic [1:0] MUL_HI = 2'd2;

  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_Z    = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]           action;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic [ID_W-1:0]            face_id0;
    logic [ID_W-1:0]            face_id1;
    logic [ID_W-1:0]            face_id2;
  } in_item_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] out_normal_x;
    logic signed [NORMAL_W-1:0] out_normal_y;
    logic signed [NORMAL_W-1:0] out_normal_z;
    logic [ID_W-1:0]            out_id0;
    logic [ID_W-1:0]            out_id1;
    logic [ID_W-1:0]            out_id2;
    logic                       flip;
    logic [CNT_W-1:0]           codir_count;
    logic [CNT_W-1:0]           antidir_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       latch_in;
    logic       exec_en;
    logic       mul_en;
    logic [1:0] mul_op;
    logic [1:0] mul_axis;
    logic       diff_en;
    logic [1:0] axis;
    logic       acc_clr;
    logic       acc_en;
    logic       acc_hi;
    logic       vote_en;
    logic       out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/mnov_ctrl.sv @@
module mnov_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [mnov_pkg::ACT_W-1:0] in_action,
  output logic                      in_ready,
  input  mnov_pkg::dp_stat_t        stat,
  output mnov_pkg::dp_cmd_t         cmd
);
  import mnov_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_CP   = 3'd2;
  localparam logic [2:0] ST_DIFF = 3'd3;
  localparam logic [2:0] ST_MLO  = 3'd4;
  localparam logic [2:0] ST_MHI  = 3'd5;
  localparam logic [2:0] ST_AHI  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       vote_pend_r, vote_pend_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    vote_pend_nxt = vote_pend_r;
    cmd           = '0;
    cmd.axis      = ax_r;
    cmd.mul_axis  = ax_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = (in_action == ACT_VOTE) ? ST_CP : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec_en = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_CP: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_CP;
        cmd.mul_axis = AX_X;
        cmd.acc_clr  = 1'b1;
        ax_nxt       = AX_X;
        state_nxt    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_LO;
        state_nxt  = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_HI;
        cmd.acc_en = 1'b1;
        state_nxt  = ST_AHI;
      end
      ST_AHI: begin
        cmd.acc_en = 1'b1;
        cmd.acc_hi = 1'b1;
        if (ax_r != AX_Z) begin
          // next axis starts its count times point product alongside
          cmd.mul_en   = 1'b1;
          cmd.mul_op   = MUL_CP;
          cmd.mul_axis = 2'(ax_r + 2'd1);
          ax_nxt       = 2'(ax_r + 2'd1);
          state_nxt    = ST_DIFF;
        end else begin
          vote_pend_nxt = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // exec of a vote item applies the sign test instead of clear or add
    if (state_r == ST_EXEC) begin
      cmd.vote_en   = vote_pend_r;
      vote_pend_nxt = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= AX_X;
      vote_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      vote_pend_r <= vote_pend_nxt;
    end
  end

endmodule

@@ src/mnov_datapath.sv @@
module mnov_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mnov_pkg::in_item_t             in_item,
  input  mnov_pkg::dp_cmd_t              cmd,
  output mnov_pkg::dp_stat_t             stat,
  input  logic                           cfg_we,
  input  logic [mnov_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mnov_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mnov_pkg::out_item_t            out_item
);
  import mnov_pkg::*;

  in_item_t item_r;
  out_item_t res, out_r;
  logic out_valid_r;

  logic                      ref_mode_r;
  logic signed [COORD_W-1:0] ref_x_r, ref_y_r, ref_z_r;
  logic signed [SUM_W-1:0]   sum_x_r, sum_y_r, sum_z_r;
  logic [CNT_W-1:0]          cnt_r, codir_r, anti_r;

  logic signed [COORD_W-1:0]  p_sel, ref_sel;
  logic signed [NORMAL_W-1:0] n_sel;
  logic signed [SUM_W-1:0]    sum_sel;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [DIFF_W-1:0]   base, d_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       codir;
  logic                       flip;

  function automatic logic signed [NORMAL_W-1:0] neg_sat(
    input logic signed [NORMAL_W-1:0] v,
    input logic                       neg
  );
    logic signed [NORMAL_W-1:0] r;
    r = v;
    if (neg) begin
      if (v == {1'b1, {(NORMAL_W-1){1'b0}}}) r = {1'b0, {(NORMAL_W-1){1'b1}}};
      else r = -v;
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_mode_r <= 1'b0;
      ref_x_r    <= '0;
      ref_y_r    <= '0;
      ref_z_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_MODE: ref_mode_r <= cfg_data[0];
        CFG_REF_X:    ref_x_r    <= signed'(cfg_data[COORD_W-1:0]);
        CFG_REF_Y:    ref_y_r    <= signed'(cfg_data[COORD_W-1:0]);
        CFG_REF_Z:    ref_z_r    <= signed'(cfg_data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  // item holding register
  always_ff @(posedge clk) begin
    if (cmd.latch_in) item_r <= in_item;
  end

  // axis selection for the multiplier
  always_comb begin
    case (cmd.mul_axis)
      AX_X:    begin p_sel = item_r.point_x; n_sel = item_r.normal_x; end
      AX_Y:    begin p_sel = item_r.point_y; n_sel = item_r.normal_y; end
      default: begin p_sel = item_r.point_z; n_sel = item_r.normal_z; end
    endcase
  end

  // axis selection for the difference
  always_comb begin
    case (cmd.axis)
      AX_X:    begin ref_sel = ref_x_r; sum_sel = sum_x_r; end
      AX_Y:    begin ref_sel = ref_y_r; sum_sel = sum_y_r; end
      default: begin ref_sel = ref_z_r; sum_sel = sum_z_r; end
    endcase
    base = ref_mode_r ? DIFF_W'(ref_sel) : DIFF_W'(sum_sel);
  end

  // shared multiplier operands: count times point, then normal times split difference
  always_comb begin
    unique case (cmd.mul_op)
      MUL_LO: begin
        mul_a = MUL_W'(n_sel);
        mul_b = signed'(MUL_W'(d_r[SPLIT-1:0]));
      end
      MUL_HI: begin
        mul_a = MUL_W'(n_sel);
        mul_b = MUL_W'(signed'(d_r[DIFF_W-1:SPLIT]));
      end
      default: begin
        // manual reference: point passes through as one times point
        mul_a = ref_mode_r ? MUL_W'(1) : signed'(MUL_W'(cnt_r));
        mul_b = MUL_W'(p_sel);
      end
    endcase
  end

  // multiply, difference and dot product accumulation
  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    if (cmd.diff_en) d_r <= base - signed'(prod_r[DIFF_W-1:0]);
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      if (cmd.acc_hi) acc_r <= acc_r + (ACC_W'(prod_r) <<< SPLIT);
      else acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign codir = !acc_r[ACC_W-1] && (acc_r != '0);

  // centroid sums and vote counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      cnt_r   <= '0;
      codir_r <= '0;
      anti_r  <= '0;
    end else if (cmd.vote_en) begin
      if (codir) begin
        if (codir_r < MAX_POINTS) codir_r <= codir_r + CNT_W'(1);
      end else begin
        if (anti_r < MAX_POINTS) anti_r <= anti_r + CNT_W'(1);
      end
    end else if (cmd.exec_en) begin
      case (item_r.action)
        ACT_CLEAR: begin
          sum_x_r <= '0;
          sum_y_r <= '0;
          sum_z_r <= '0;
          cnt_r   <= '0;
          codir_r <= '0;
          anti_r  <= '0;
        end
        ACT_ADD_POINT: begin
          if (cnt_r < MAX_POINTS) begin
            sum_x_r <= sum_x_r + SUM_W'(item_r.point_x);
            sum_y_r <= sum_y_r + SUM_W'(item_r.point_y);
            sum_z_r <= sum_z_r + SUM_W'(item_r.point_z);
            cnt_r   <= cnt_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result item
  assign flip = (anti_r > codir_r);

  always_comb begin
    res               = '0;
    res.flip          = flip;
    res.codir_count   = codir_r;
    res.antidir_count = anti_r;
    case (item_r.action)
      ACT_FLIP_NORMAL: begin
        res.out_normal_x = neg_sat(item_r.normal_x, flip);
        res.out_normal_y = neg_sat(item_r.normal_y, flip);
        res.out_normal_z = neg_sat(item_r.normal_z, flip);
      end
      ACT_FLIP_FACE: begin
        res.out_id0 = flip ? item_r.face_id2 : item_r.face_id0;
        res.out_id1 = item_r.face_id1;
        res.out_id2 = flip ? item_r.face_id0 : item_r.face_id2;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

endmodule

@@ src/mesh_normal_orientation_vote_core.sv @@
// Normal orientation majority vote for a triangle mesh, driven in host passes.
// Input channel (in_valid/in_ready/in_item) takes one action per item: clear,
// add_point, vote, flip_normal or flip_face. Every item gives exactly one result
// on the output channel (out_valid/out_ready/out_item) with the current flip
// decision and both vote counters.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready and sets the reference mode and manual reference point; write it only
// while no item is in flight.
// Items are handled one at a time: the input is not ready again until the
// last result is loaded into the output register. A vote item works through the
// single shared 25x25 multiplier, which runs three products per axis (count times
// point, then normal times the low and high halves of the difference); every
// other action bypasses the multiplier.
// A finished result sits in an output register, so the next item is accepted and
// worked on while the receiver stalls; only the final hand-over waits for it.
// Synchronous reset clears the sums, counters, configuration and state registers and the output valid.
module mesh_normal_orientation_vote_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mnov_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mnov_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mnov_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mnov_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mnov_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  mnov_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_item.action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic, state and output register
  mnov_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ src/mnov_checker.sv @@
module mnov_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input mnov_pkg::out_item_t            out_item
);
  import mnov_pkg::*;

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // one item at a time: an accepted item closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after acceptance");

  // flip agrees with the counters it is shown with
  a_flip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.flip == (out_item.antidir_count > out_item.codir_count)))
    else $error("flip disagrees with counters");

  // counters saturate at the point limit
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.codir_count <= MAX_POINTS) &&
                  (out_item.antidir_count <= MAX_POINTS))
    else $error("vote counter beyond limit");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind mesh_normal_orientation_vote_core mnov_checker u_chk (.*);
